// ===== rtl/core/qmn_pkg.sv =====
package qmn_pkg;

    // component format: signed Q2.14 by default
    localparam int CW     = 16;
    localparam int FRAC   = CW - 2;
    // magnitude of one product component (sum of four products)
    localparam int RW     = 2 * CW + 1;
    // signed component before abs
    localparam int RSW    = RW + 1;
    // sum of four squares
    localparam int SW     = 2 * RW + 1;
    // radicand padded to an even width, and root width
    localparam int SQW    = SW + (SW % 2);
    localparam int ROOT_W = SQW / 2;
    // queue between front and back
    localparam int QD     = 4;
    localparam int QAW    = 2;

    localparam logic [CW:0] HALF_POS = (CW + 1)'(2 ** (CW - 1) - 1);
    localparam logic [CW:0] HALF_NEG = (CW + 1)'(2 ** (CW - 1));

    // one classified item handed from front to back
    typedef struct packed {
        logic [3:0]          neg;
        logic [3:0][RW-1:0]  mag;
        logic                zero;
        logic [SW-1:0]       ssum;
    } work_t;

    // one step of the digit-by-digit square root
    typedef struct packed {
        logic [ROOT_W+1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [SQW-1:0]    rad;
    } sqrt_t;

    // one lane of the restoring divider
    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [CW-1:0]     low;
        logic [CW-1:0]     quo;
    } div_t;

    function automatic sqrt_t sqrt_step(input sqrt_t a);
        logic [ROOT_W+3:0] t;
        logic [ROOT_W+3:0] tr;
        sqrt_t r;
        t = {a.rem, a.rad[SQW-1 -: 2]};
        tr = {2'b00, a.root, 2'b01};
        r.rad = {a.rad[SQW-3:0], 2'b00};
        if (t >= tr)
        begin
            r.rem = (ROOT_W + 2)'(t - tr);
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[ROOT_W+1:0];
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic div_t div_step(input div_t a, input logic [ROOT_W-1:0] n);
        logic [ROOT_W:0] t;
        logic [ROOT_W:0] nn;
        div_t r;
        t = {a.rem, a.low[CW-1]};
        nn = {1'b0, n};
        r.low = {a.low[CW-2:0], 1'b0};
        if (t >= nn)
        begin
            r.rem = ROOT_W'(t - nn);
            r.quo = {a.quo[CW-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[ROOT_W-1:0];
            r.quo = {a.quo[CW-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/qmn_if.sv =====
interface qmn_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [qmn_pkg::CW-1:0]     q_scalar;
    logic signed [qmn_pkg::CW-1:0]     q_x;
    logic signed [qmn_pkg::CW-1:0]     q_y;
    logic signed [qmn_pkg::CW-1:0]     q_z;
    logic signed [qmn_pkg::CW-1:0]     p_scalar;
    logic signed [qmn_pkg::CW-1:0]     p_x;
    logic signed [qmn_pkg::CW-1:0]     p_y;
    logic signed [qmn_pkg::CW-1:0]     p_z;

    modport source(output valid, q_scalar, q_x, q_y, q_z, p_scalar, p_x, p_y, p_z,
                   input ready);
    modport sink(input valid, q_scalar, q_x, q_y, q_z, p_scalar, p_x, p_y, p_z,
                 output ready);
endinterface

interface qmn_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [qmn_pkg::CW-1:0]     r_scalar;
    logic signed [qmn_pkg::CW-1:0]     r_x;
    logic signed [qmn_pkg::CW-1:0]     r_y;
    logic signed [qmn_pkg::CW-1:0]     r_z;
    logic                              zero_norm;

    modport source(output valid, r_scalar, r_x, r_y, r_z, zero_norm, input ready);
    modport sink(input valid, r_scalar, r_x, r_y, r_z, zero_norm, output ready);
endinterface

// ===== rtl/core/qmn_front.sv =====
module qmn_front
(
    input  logic            clk,
    input  logic            rst_n,
    qmn_in_if.sink          in_ch,
    output logic            wk_valid,
    output qmn_pkg::work_t  wk,
    input  logic            wk_ready
);

    logic en;

    logic [4:0] v_reg;
    logic signed [qmn_pkg::RSW-1:0] prod_reg [16];
    logic signed [qmn_pkg::RSW-1:0] sum_reg [4];
    logic [3:0] neg_reg [2];
    logic [qmn_pkg::RW-1:0] mag_reg [2][4];
    logic zero_reg [2];
    logic [2*qmn_pkg::RW-1:0] sq_reg [4];
    qmn_pkg::work_t out_reg;

    logic signed [qmn_pkg::RSW-1:0] sum_next [4];
    logic [3:0] neg_next;
    logic [qmn_pkg::RW-1:0] mag_next [4];

    // whole front advances together while the queue has room
    assign en = wk_ready;
    assign in_ch.ready = en;
    assign wk_valid = v_reg[4];
    assign wk = out_reg;

    // Hamilton product terms
    always_comb
    begin
        sum_next[0] = prod_reg[0] - prod_reg[1] - prod_reg[2] - prod_reg[3];
        sum_next[1] = prod_reg[4] + prod_reg[5] + prod_reg[6] - prod_reg[7];
        sum_next[2] = prod_reg[8] + prod_reg[9] + prod_reg[10] - prod_reg[11];
        sum_next[3] = prod_reg[12] + prod_reg[13] + prod_reg[14] - prod_reg[15];
    end

    // magnitudes, signs flipped when the scalar part is negative
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            neg_next[i] = sum_reg[i][qmn_pkg::RSW-1] ^ sum_reg[0][qmn_pkg::RSW-1];
            if (sum_reg[i][qmn_pkg::RSW-1])
                mag_next[i] = qmn_pkg::RW'(-sum_reg[i]);
            else
                mag_next[i] = qmn_pkg::RW'(sum_reg[i]);
        end
    end

    // valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_ch.valid};
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0]  <= in_ch.q_scalar * in_ch.p_scalar;
            prod_reg[1]  <= in_ch.q_x * in_ch.p_x;
            prod_reg[2]  <= in_ch.q_y * in_ch.p_y;
            prod_reg[3]  <= in_ch.q_z * in_ch.p_z;
            prod_reg[4]  <= in_ch.q_scalar * in_ch.p_x;
            prod_reg[5]  <= in_ch.p_scalar * in_ch.q_x;
            prod_reg[6]  <= in_ch.q_y * in_ch.p_z;
            prod_reg[7]  <= in_ch.q_z * in_ch.p_y;
            prod_reg[8]  <= in_ch.q_scalar * in_ch.p_y;
            prod_reg[9]  <= in_ch.p_scalar * in_ch.q_y;
            prod_reg[10] <= in_ch.q_z * in_ch.p_x;
            prod_reg[11] <= in_ch.q_x * in_ch.p_z;
            prod_reg[12] <= in_ch.q_scalar * in_ch.p_z;
            prod_reg[13] <= in_ch.p_scalar * in_ch.q_z;
            prod_reg[14] <= in_ch.q_x * in_ch.p_y;
            prod_reg[15] <= in_ch.q_y * in_ch.p_x;
            for (int i = 0; i < 4; i++)
            begin
                sum_reg[i] <= sum_next[i];
                mag_reg[0][i] <= mag_next[i];
                mag_reg[1][i] <= mag_reg[0][i];
                sq_reg[i] <= mag_reg[0][i] * mag_reg[0][i];
            end
            neg_reg[0] <= neg_next;
            neg_reg[1] <= neg_reg[0];
            zero_reg[0] <= (mag_next[0] == '0) && (mag_next[1] == '0)
                        && (mag_next[2] == '0) && (mag_next[3] == '0);
            zero_reg[1] <= zero_reg[0];
            out_reg.neg <= neg_reg[1];
            for (int i = 0; i < 4; i++)
                out_reg.mag[i] <= mag_reg[1][i];
            out_reg.zero <= zero_reg[1];
            out_reg.ssum <= qmn_pkg::SW'(sq_reg[0]) + qmn_pkg::SW'(sq_reg[1])
                          + qmn_pkg::SW'(sq_reg[2]) + qmn_pkg::SW'(sq_reg[3]);
        end
    end

endmodule

// ===== rtl/core/qmn_queue.sv =====
module qmn_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  qmn_pkg::work_t  push_data,
    output logic            push_ready,
    output logic            pop_valid,
    output qmn_pkg::work_t  pop_data,
    input  logic            pop_ready
);

    qmn_pkg::work_t mem_reg [qmn_pkg::QD];
    logic [qmn_pkg::QAW-1:0] wr_reg;
    logic [qmn_pkg::QAW-1:0] rd_reg;
    logic [qmn_pkg::QAW:0] cnt_reg;
    logic push;
    logic pop;

    assign push_ready = (cnt_reg != qmn_pkg::QD[qmn_pkg::QAW:0]);
    assign pop_valid = (cnt_reg != '0);
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;
    assign pop_data = mem_reg[rd_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/qmn_back.sv =====
module qmn_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wk_valid,
    input  qmn_pkg::work_t  wk,
    output logic            wk_ready,
    qmn_out_if.source       out_ch
);

    localparam int NS = qmn_pkg::ROOT_W + 1;
    localparam int ND = qmn_pkg::CW + 1;

    logic en;

    // square root stages
    logic [NS-1:0] sv_reg;
    qmn_pkg::sqrt_t sq_reg [NS];
    logic [qmn_pkg::RW-1:0] smag_reg [NS][4];
    logic [3:0] sneg_reg [NS];
    logic szero_reg [NS];

    // divider stages, four lanes sharing one divisor
    logic [ND-1:0] dv_reg;
    qmn_pkg::div_t dl_reg [ND][4];
    logic [qmn_pkg::ROOT_W-1:0] dn_reg [ND];
    logic [3:0] dneg_reg [ND];
    logic dzero_reg [ND];

    // output register
    logic ov_reg;
    logic [3:0][qmn_pkg::CW-1:0] res_reg;
    logic zf_reg;

    logic [3:0][qmn_pkg::CW-1:0] res_next;

    assign en = !ov_reg || out_ch.ready;
    assign wk_ready = en;
    assign out_ch.valid = ov_reg;
    assign out_ch.r_scalar = res_reg[0];
    assign out_ch.r_x = res_reg[1];
    assign out_ch.r_y = res_reg[2];
    assign out_ch.r_z = res_reg[3];
    assign out_ch.zero_norm = zf_reg;

    // rounding, clamp, sign and zero-norm override of the last divider stage
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic [qmn_pkg::CW:0] q;
            q = {1'b0, dl_reg[ND-1][i].quo};
            if ({dl_reg[ND-1][i].rem, 1'b0} >= {1'b0, dn_reg[ND-1]})
                q = q + 1'b1;
            if (dzero_reg[ND-1])
                res_next[i] = '0;
            else if (dneg_reg[ND-1][i])
            begin
                if (q > qmn_pkg::HALF_NEG)
                    q = qmn_pkg::HALF_NEG;
                res_next[i] = qmn_pkg::CW'((qmn_pkg::CW + 1)'(0) - q);
            end
            else
            begin
                if (q > qmn_pkg::HALF_POS)
                    q = qmn_pkg::HALF_POS;
                res_next[i] = q[qmn_pkg::CW-1:0];
            end
        end
    end

    // valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= '0;
            dv_reg <= '0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_reg <= {sv_reg[NS-2:0], wk_valid};
            dv_reg <= {dv_reg[ND-2:0], sv_reg[NS-1]};
            ov_reg <= dv_reg[ND-1];
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // load square root
            sq_reg[0].rem <= '0;
            sq_reg[0].root <= '0;
            sq_reg[0].rad <= qmn_pkg::SQW'(wk.ssum);
            sneg_reg[0] <= wk.neg;
            szero_reg[0] <= wk.zero;
            for (int i = 0; i < 4; i++)
                smag_reg[0][i] <= wk.mag[i];
            // one root bit per stage
            for (int s = 1; s < NS; s++)
            begin
                sq_reg[s] <= qmn_pkg::sqrt_step(sq_reg[s-1]);
                sneg_reg[s] <= sneg_reg[s-1];
                szero_reg[s] <= szero_reg[s-1];
                for (int i = 0; i < 4; i++)
                    smag_reg[s][i] <= smag_reg[s-1][i];
            end
            // load divider: numerator is magnitude shifted up by the fraction bits
            dn_reg[0] <= sq_reg[NS-1].root;
            dneg_reg[0] <= sneg_reg[NS-1];
            dzero_reg[0] <= szero_reg[NS-1];
            for (int i = 0; i < 4; i++)
            begin
                dl_reg[0][i].rem <= qmn_pkg::ROOT_W'(smag_reg[NS-1][i][qmn_pkg::RW-1:2]);
                dl_reg[0][i].low <= {smag_reg[NS-1][i][1:0], {qmn_pkg::FRAC{1'b0}}};
                dl_reg[0][i].quo <= '0;
            end
            // one quotient bit per stage
            for (int s = 1; s < ND; s++)
            begin
                dn_reg[s] <= dn_reg[s-1];
                dneg_reg[s] <= dneg_reg[s-1];
                dzero_reg[s] <= dzero_reg[s-1];
                for (int i = 0; i < 4; i++)
                    dl_reg[s][i] <= qmn_pkg::div_step(dl_reg[s-1][i], dn_reg[s-1]);
            end
            res_reg <= res_next;
            zf_reg <= dzero_reg[ND-1];
        end
    end

endmodule

// ===== rtl/core/quaternion_multiply_normalize_top.sv =====
// The front registers products, sums, abs, squares and the sum of squares; then come the
// queue, 35 root stages, 17 divider stages and the output register; root and divider are
// fully pipelined, one bit per stage. Throughput: one item per cycle while out_ch is ready.
// Reset (rst_n, async, active low) clears the valid pipes and the queue; no other state.
module quaternion_multiply_normalize_top
(
    input  logic        clk,
    input  logic        rst_n,
    qmn_in_if.sink      in_ch,
    qmn_out_if.source   out_ch
);

    logic            f_valid;
    qmn_pkg::work_t  f_data;
    logic            f_ready;
    logic            b_valid;
    qmn_pkg::work_t  b_data;
    logic            b_ready;

    qmn_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .wk_valid (f_valid),
        .wk       (f_data),
        .wk_ready (f_ready)
    );

    qmn_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_data  (f_data),
        .push_ready (f_ready),
        .pop_valid  (b_valid),
        .pop_data   (b_data),
        .pop_ready  (b_ready)
    );

    qmn_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wk_valid (b_valid),
        .wk       (b_data),
        .wk_ready (b_ready),
        .out_ch   (out_ch)
    );

endmodule

// ===== test/quaternion_multiply_normalize_top_test.sv =====
`timescale 1ns / 100ps

module quaternion_multiply_normalize_top_test;

    localparam int STIM_LEN = 20;
    localparam int RANDOM_ITEMS = 1200;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic signed [qmn_pkg::CW-1:0] s;
        logic signed [qmn_pkg::CW-1:0] x;
        logic signed [qmn_pkg::CW-1:0] y;
        logic signed [qmn_pkg::CW-1:0] z;
    } quat_t;

    typedef struct packed {
        logic signed [qmn_pkg::CW-1:0] s;
        logic signed [qmn_pkg::CW-1:0] x;
        logic signed [qmn_pkg::CW-1:0] y;
        logic signed [qmn_pkg::CW-1:0] z;
        logic                          zero_norm;
    } rot_t;

    typedef struct {
        quat_t q;
        quat_t p;
        bit    typed;
        rot_t  want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    bit   stim_done;
    rot_t pending_rots[$];
    stim_row_t stim_rows[STIM_LEN];

    qmn_in_if  in_ch();
    qmn_out_if out_ch();

    quaternion_multiply_normalize_top dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // floor(sqrt(v)) over the full sum-of-squares width
    function automatic logic [qmn_pkg::ROOT_W-1:0] floor_root(input logic [qmn_pkg::SQW-1:0] v);
        logic [qmn_pkg::ROOT_W-1:0] r;
        logic [qmn_pkg::ROOT_W-1:0] t;
        r = '0;
        for (int k = qmn_pkg::ROOT_W - 1; k >= 0; k--)
        begin
            t = r | (qmn_pkg::ROOT_W'(1) << k);
            if (qmn_pkg::SQW'(t) * qmn_pkg::SQW'(t) <= v)
                r = t;
        end
        return r;
    endfunction

    // normalized, sign-fixed Hamilton product
    function automatic rot_t hamilton_normalized(input quat_t a, input quat_t b);
        logic signed [qmn_pkg::RSW+1:0]                  c [4];
        logic [qmn_pkg::RW:0]                            m [4];
        logic [qmn_pkg::SQW-1:0]                         ssum;
        logic [qmn_pkg::ROOT_W-1:0]                      n;
        logic [qmn_pkg::ROOT_W+qmn_pkg::FRAC+1:0]        num;
        logic [qmn_pkg::ROOT_W+qmn_pkg::FRAC+1:0]        o;
        logic [qmn_pkg::ROOT_W+qmn_pkg::FRAC+1:0]        rem;
        logic signed [qmn_pkg::CW:0]                     v [4];
        rot_t r;
        c[0] = a.s * b.s - a.x * b.x - a.y * b.y - a.z * b.z;
        c[1] = a.s * b.x + b.s * a.x + a.y * b.z - a.z * b.y;
        c[2] = a.s * b.y + b.s * a.y + a.z * b.x - a.x * b.z;
        c[3] = a.s * b.z + b.s * a.z + a.x * b.y - a.y * b.x;
        if (c[0] < 0)
            for (int i = 0; i < 4; i++)
                c[i] = -c[i];
        ssum = '0;
        for (int i = 0; i < 4; i++)
        begin
            m[i] = (c[i] < 0) ? (qmn_pkg::RW + 1)'(-c[i]) : (qmn_pkg::RW + 1)'(c[i]);
            ssum += qmn_pkg::SQW'(m[i]) * qmn_pkg::SQW'(m[i]);
        end
        r = '0;
        if (ssum == 0)
        begin
            r.zero_norm = 1'b1;
            return r;
        end
        n = floor_root(ssum);
        for (int i = 0; i < 4; i++)
        begin
            num = (qmn_pkg::ROOT_W + qmn_pkg::FRAC + 2)'(m[i]) << qmn_pkg::FRAC;
            o = num / n;
            rem = num - o * n;
            if (2 * rem >= n)
                o++;
            if (c[i] < 0)
                v[i] = (o > (1 << (qmn_pkg::CW - 1)))
                     ? -(qmn_pkg::CW + 1)'(1 << (qmn_pkg::CW - 1))
                     : -(qmn_pkg::CW + 1)'(o);
            else
                v[i] = (o > (1 << (qmn_pkg::CW - 1)) - 1)
                     ? (qmn_pkg::CW + 1)'((1 << (qmn_pkg::CW - 1)) - 1)
                     : (qmn_pkg::CW + 1)'(o);
        end
        r.s = v[0][qmn_pkg::CW-1:0];
        r.x = v[1][qmn_pkg::CW-1:0];
        r.y = v[2][qmn_pkg::CW-1:0];
        r.z = v[3][qmn_pkg::CW-1:0];
        return r;
    endfunction

    function automatic quat_t rand_quat();
        quat_t q;
        q = {$urandom, $urandom};
        if ($urandom_range(0, 5) == 0)
            q.s = 16'sh4000;
        if ($urandom_range(0, 7) == 0)
            q.x = 0;
        return q;
    endfunction

    function automatic quat_t mk(input int s, input int x, input int y, input int z);
        quat_t q;
        q.s = qmn_pkg::CW'(s);
        q.x = qmn_pkg::CW'(x);
        q.y = qmn_pkg::CW'(y);
        q.z = qmn_pkg::CW'(z);
        return q;
    endfunction

    // directed rows; expected values typed in only for obvious cases
    initial
    begin
        rot_t zr;
        rot_t id;
        zr = '0;
        zr.zero_norm = 1'b1;
        id = '0;
        id.s = 16'sh4000;
        stim_rows[0]  = '{mk(0, 0, 0, 0), mk(0, 0, 0, 0), 1, zr};
        stim_rows[1]  = '{mk(16384, 0, 0, 0), mk(16384, 0, 0, 0), 1, id};
        stim_rows[2]  = '{mk(16384, 0, 0, 0), mk(0, 0, 0, 0), 1, zr};
        stim_rows[3]  = '{mk(-16384, 0, 0, 0), mk(16384, 0, 0, 0), 1, id};
        stim_rows[4]  = '{mk(-32768, -32768, -32768, -32768), mk(-32768, -32768, -32768, -32768),
                          0, zr};
        stim_rows[5]  = '{mk(32767, 32767, 32767, 32767), mk(32767, 32767, 32767, 32767), 0, zr};
        stim_rows[6]  = '{mk(-32768, 0, 0, 0), mk(32767, 0, 0, 0), 0, zr};
        stim_rows[7]  = '{mk(0, 16384, 0, 0), mk(0, 16384, 0, 0), 1, id};
        stim_rows[8]  = '{mk(0, 1, 0, 0), mk(0, 0, 1, 0), 0, zr};
        stim_rows[9]  = '{mk(1, 0, 0, 0), mk(1, 0, 0, 0), 0, zr};
        stim_rows[10] = '{mk(11585, 11585, 0, 0), mk(11585, 0, 11585, 0), 0, zr};
        stim_rows[11] = '{mk(-1, -1, -1, -1), mk(1, 1, 1, 1), 0, zr};
        stim_rows[12] = '{mk(32767, -32768, 32767, -32768), mk(-32768, 32767, -32768, 32767),
                          0, zr};
        stim_rows[13] = '{mk(0, 0, 0, 16384), mk(0, 0, 16384, 0), 0, zr};
        stim_rows[14] = '{mk(21845, -5461, 1000, -7), mk(-3, 30000, -12345, 4096), 0, zr};
        stim_rows[15] = '{mk(0, 0, 0, 0), mk(32767, -32768, 1, -1), 1, zr};
        stim_rows[16] = '{mk(0, 0, 0, -32768), mk(0, 0, 0, -32768), 0, zr};
        stim_rows[17] = '{mk(1, 2, 3, 4), mk(5, -6, 7, -8), 0, zr};
        stim_rows[18] = '{mk(-16384, 0, 0, 0), mk(0, 16384, 0, 0), 0, zr};
        stim_rows[19] = '{mk(0, 0, 1, 0), mk(0, 0, 0, 1), 0, zr};
    end

    task automatic send_pair(input quat_t a, input quat_t b, input bit typed, input rot_t want);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.q_scalar <= a.s;
        in_ch.q_x      <= a.x;
        in_ch.q_y      <= a.y;
        in_ch.q_z      <= a.z;
        in_ch.p_scalar <= b.s;
        in_ch.p_x      <= b.x;
        in_ch.p_y      <= b.y;
        in_ch.p_z      <= b.z;
        do @(posedge clk); while (!in_ch.ready);
        pending_rots.push_back(typed ? want : hamilton_normalized(a, b));
    endtask

    // source side
    initial
    begin
        in_ch.valid    = 1'b0;
        in_ch.q_scalar = '0;
        in_ch.q_x      = '0;
        in_ch.q_y      = '0;
        in_ch.q_z      = '0;
        in_ch.p_scalar = '0;
        in_ch.p_x      = '0;
        in_ch.p_y      = '0;
        in_ch.p_z      = '0;
        fail_count     = 0;
        stim_done      = 1'b0;
        rst_n          = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < STIM_LEN; i++)
            send_pair(stim_rows[i].q, stim_rows[i].p, stim_rows[i].typed, stim_rows[i].want);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_pair(rand_quat(), rand_quat(), 1'b0, '0);
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // sink side: random stalls, compare each accepted item
    initial
    begin
        int   stall;
        rot_t want;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            if (pending_rots.size() == 0)
            begin
                $error("unexpected result item");
                fail_count++;
            end
            else
            begin
                want = pending_rots.pop_front();
                if (out_ch.r_scalar !== want.s)
                begin
                    $error("r_scalar: expected %0d, got %0d", want.s, out_ch.r_scalar);
                    fail_count++;
                end
                if (out_ch.r_x !== want.x)
                begin
                    $error("r_x: expected %0d, got %0d", want.x, out_ch.r_x);
                    fail_count++;
                end
                if (out_ch.r_y !== want.y)
                begin
                    $error("r_y: expected %0d, got %0d", want.y, out_ch.r_y);
                    fail_count++;
                end
                if (out_ch.r_z !== want.z)
                begin
                    $error("r_z: expected %0d, got %0d", want.z, out_ch.r_z);
                    fail_count++;
                end
                if (out_ch.zero_norm !== want.zero_norm)
                begin
                    $error("zero_norm: expected %0d, got %0d", want.zero_norm, out_ch.zero_norm);
                    fail_count++;
                end
            end
        end
    end

    // end of run
    initial
    begin
        wait (stim_done);
        wait (pending_rots.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_rots.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // timeout
    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/qmn_pkg.sv
rtl/core/qmn_if.sv
rtl/core/qmn_front.sv
rtl/core/qmn_queue.sv
rtl/core/qmn_back.sv
rtl/core/quaternion_multiply_normalize_top.sv
test/quaternion_multiply_normalize_top_test.sv
